// ===== design/tcge_pkg.sv =====
package tcge_pkg;

    // Window and credit width; the product, sum and counter widths follow from it.
    localparam int WINDOW_BITS = 32;

    localparam int DATA_W    = 32;
    localparam int MSS_W     = 16;
    localparam int CFG_IDX_W = 1;
    localparam int PROD_W    = WINDOW_BITS + MSS_W;
    localparam int SUM_W     = PROD_W + 1;
    localparam int CNT_W     = $clog2(WINDOW_BITS);

    localparam logic [WINDOW_BITS-1:0] WMAX = {WINDOW_BITS{1'b1}};

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MSS      = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_WIN = 1'b1;

    // Update actions.
    localparam logic ACT_SLOW_START = 1'b0;
    localparam logic ACT_AVOID      = 1'b1;

    localparam logic [MSS_W-1:0]  MSS_RESET      = 16'd536;
    localparam logic [DATA_W-1:0] INIT_WIN_RESET = 32'd1072;

    typedef struct packed {
        logic load_in;
        logic pre;
        logic div_init;
        logic div_step;
        logic mul;
        logic add;
        logic load_out;
    } tcge_cmd_t;

    typedef struct packed {
        logic action;
        logic need_div;
    } tcge_status_t;

    // Clamp a widened sum to the largest window value.
    function automatic logic [WINDOW_BITS-1:0] sat_win(input logic [SUM_W-1:0] s);
        logic [WINDOW_BITS-1:0] r;
        if (s > SUM_W'(WMAX))
        begin
            r = WMAX;
        end
        else
        begin
            r = s[WINDOW_BITS-1:0];
        end
        return r;
    endfunction

endpackage

// ===== design/tcge_ack_if.sv =====
interface tcge_ack_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [31:0] acked_bytes;
    logic [31:0] growth_divisor;
    logic        rto_recovery;

    modport source (output valid, output action, output acked_bytes,
                    output growth_divisor, output rto_recovery, input ready);
    modport sink   (input valid, input action, input acked_bytes,
                    input growth_divisor, input rto_recovery, output ready);
endinterface

// ===== design/tcge_cwnd_if.sv =====
interface tcge_cwnd_if;
    logic        valid;
    logic        ready;
    logic [31:0] congestion_window;

    modport source (output valid, output congestion_window, input ready);
    modport sink   (input valid, input congestion_window, output ready);
endinterface

// ===== design/tcge_ctrl.sv =====
module tcge_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  tcge_pkg::tcge_status_t status,
    output tcge_pkg::tcge_cmd_t   cmd
);
    import tcge_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PRE,
        S_CHK,
        S_DIV,
        S_MUL,
        S_ADD,
        S_FIN
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_PRE;
                end
            end
            S_PRE:
            begin
                cmd.pre    = 1'b1;
                state_next = (status.action == ACT_AVOID) ? S_CHK : S_FIN;
            end
            S_CHK:
            begin
                if (status.need_div)
                begin
                    cmd.div_init = 1'b1;
                    cnt_next     = CNT_W'(WINDOW_BITS - 1);
                    state_next   = S_DIV;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_ADD;
            end
            S_ADD:
            begin
                cmd.add    = 1'b1;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // A second word is never taken while one is in work.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while busy");

    // An untaken result is never overwritten.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> !out_valid_reg || out_ready)
        else $error("result overwritten");

    // The divider always starts with the full iteration count.
    a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CHK && status.need_div |=>
            state_reg == S_DIV && cnt_reg == CNT_W'(WINDOW_BITS - 1))
        else $error("divider started with wrong count");

    // The last division step hands over to the multiply.
    a_div_end: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV && cnt_reg == '0 |=> state_reg == S_MUL)
        else $error("divider did not finish");

endmodule

// ===== design/tcge_datapath.sv =====
module tcge_datapath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [tcge_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tcge_pkg::DATA_W-1:0]     cfg_wdata,
    input  logic                            action,
    input  logic [tcge_pkg::DATA_W-1:0]     acked_bytes,
    input  logic [tcge_pkg::DATA_W-1:0]     growth_divisor,
    input  logic                            rto_recovery,
    input  tcge_pkg::tcge_cmd_t             cmd,
    output tcge_pkg::tcge_status_t          status,
    output logic [tcge_pkg::DATA_W-1:0]     congestion_window
);
    import tcge_pkg::*;

    logic [MSS_W-1:0]       mss_reg;
    logic [WINDOW_BITS-1:0] window_reg, window_next;
    logic [WINDOW_BITS-1:0] credit_reg, credit_next;

    logic                   action_reg;
    logic                   rto_reg;
    logic [DATA_W-1:0]      acked_reg;
    logic [DATA_W-1:0]      div_reg;

    logic [DATA_W-1:0]      rem_reg, rem_next;
    logic [WINDOW_BITS-1:0] quo_reg, quo_next;
    logic [PROD_W-1:0]      prod_reg;
    logic [DATA_W-1:0]      out_data_reg;

    logic                   credit_full;
    logic [MSS_W:0]         ss_cap;
    logic [MSS_W:0]         ss_add;
    logic [WINDOW_BITS-1:0] credit_base;
    logic [DATA_W:0]        trial;
    logic                   trial_ge;

    assign credit_full     = DATA_W'(credit_reg) >= div_reg;
    assign status.action   = action_reg;
    assign status.need_div = credit_full;
    assign congestion_window = out_data_reg;

    // Slow start growth is capped at one or two segments.
    assign ss_cap = rto_reg ? {1'b0, mss_reg} : {mss_reg, 1'b0};
    assign ss_add = (acked_reg < DATA_W'(ss_cap)) ? acked_reg[MSS_W:0] : ss_cap;

    assign credit_base = credit_full ? '0 : credit_reg;

    // One restoring division step per cycle; the credit is the dividend.
    assign trial    = {rem_reg, quo_reg[WINDOW_BITS-1]};
    assign trial_ge = trial >= {1'b0, div_reg};

    always_comb
    begin
        window_next = window_reg;
        credit_next = credit_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        if (cmd.pre)
        begin
            if (action_reg == ACT_SLOW_START)
            begin
                window_next = sat_win(SUM_W'(window_reg) + SUM_W'(ss_add));
            end
            else
            begin
                if (credit_full)
                begin
                    window_next = sat_win(SUM_W'(window_reg) + SUM_W'(mss_reg));
                end
                credit_next = sat_win(SUM_W'(credit_base) + SUM_W'(acked_reg));
            end
        end
        if (cmd.div_init)
        begin
            rem_next = '0;
            quo_next = credit_reg;
        end
        if (cmd.div_step)
        begin
            rem_next = trial_ge ? DATA_W'(trial - {1'b0, div_reg}) : trial[DATA_W-1:0];
            quo_next = {quo_reg[WINDOW_BITS-2:0], trial_ge};
        end
        if (cmd.add)
        begin
            window_next = sat_win(SUM_W'(window_reg) + SUM_W'(prod_reg));
            credit_next = rem_reg[WINDOW_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mss_reg      <= MSS_RESET;
            window_reg   <= sat_win(SUM_W'(INIT_WIN_RESET));
            credit_reg   <= '0;
        end
        else if (cfg_wr_en && cfg_index == CFG_INIT_WIN)
        begin
            window_reg   <= sat_win(SUM_W'(cfg_wdata));
            credit_reg   <= '0;
        end
        else
        begin
            if (cfg_wr_en && cfg_index == CFG_MSS)
            begin
                mss_reg <= cfg_wdata[MSS_W-1:0];
            end
            window_reg <= window_next;
            credit_reg <= credit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            action_reg <= action;
            rto_reg    <= rto_recovery;
            acked_reg  <= acked_bytes;
            div_reg    <= (growth_divisor == '0) ? DATA_W'(1) : growth_divisor;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (cmd.mul)
        begin
            prod_reg <= PROD_W'(quo_reg) * PROD_W'(mss_reg);
        end
        if (cmd.load_out)
        begin
            out_data_reg <= DATA_W'(window_reg);
        end
    end

endmodule

// ===== design/tcp_cwnd_growth_engine_top.sv =====
// Slow start runs the load and slow start steps; congestion avoidance adds a credit check and, when the
// credit holds at least one divisor, the 32-step restoring division, a multiply and a window add.
// A new ACK word is taken only after the last one's window word is loaded into the output register.
// The output register holds a finished word, so a new ACK word is taken while it waits.
// Reset (async, active low) loads MSS 536, window 1072 and zero credit.
module tcp_cwnd_growth_engine_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [tcge_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tcge_pkg::DATA_W-1:0]    cfg_wdata,
    tcge_ack_if.sink                       ack,
    tcge_cwnd_if.source                    cwnd
);
    import tcge_pkg::*;

    tcge_cmd_t    cmd;
    tcge_status_t status;

    // The controller sequences one ACK word at a time: a load cycle, the
    // slow start or first avoidance step, for avoidance a credit check and,
    // when the credit holds at least one divisor, a bit-per-cycle division, a
    // multiply of the quotient by the MSS and a saturating window add, then the output load.
    tcge_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (ack.valid),
        .in_ready  (ack.ready),
        .out_valid (cwnd.valid),
        .out_ready (cwnd.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // The datapath holds the configuration, the window and credit state, the
    // latched ACK fields, the divider and product registers and the output word register.
    tcge_datapath u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .action            (ack.action),
        .acked_bytes       (ack.acked_bytes),
        .growth_divisor    (ack.growth_divisor),
        .rto_recovery      (ack.rto_recovery),
        .cmd               (cmd),
        .status            (status),
        .congestion_window (cwnd.congestion_window)
    );

endmodule
